// ----- src/gamepad_report_to_key_events_assert.svh -----
// Assertion macros used by the checker module of the gamepad decoder.
`ifndef GAMEPAD_REPORT_TO_KEY_EVENTS_ASSERT_SVH
`define GAMEPAD_REPORT_TO_KEY_EVENTS_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define GPKEV_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("gamepad decoder assertion failed");

// Condition that must hold in the cycle after its trigger.
`define GPKEV_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("gamepad decoder assertion failed");

`endif

// ----- src/gpkev_pkg.sv -----
// Package with types, constants and tables of the gamepad report decoder.
`default_nettype none
package gpkev_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 4;
	localparam int NUM_KEYS = 10;
	localparam int MIN_REPORT_LEN = 14;

	localparam logic [15:0] TILT_THRESHOLD_RESET = 16'd22000;
	localparam logic [7:0] TRIGGER_DELTA_RESET = 8'd20;
	localparam logic [15:0] AXIS_DELTA_RESET = 16'd2000;

	typedef enum logic [1:0] {
		CFG_OUTPUT_MODE,
		CFG_TILT_THRESHOLD,
		CFG_TRIGGER_DELTA,
		CFG_AXIS_DELTA
	} cfg_idx_t;

	localparam logic OPC_REPORT = 1'b0;
	localparam logic OPC_RELEASE_ALL = 1'b1;

	localparam logic KIND_KEY = 1'b0;
	localparam logic KIND_PAD = 1'b1;

	localparam logic [3:0] HAT_UP = 4'd0;
	localparam logic [3:0] HAT_UP_RIGHT = 4'd1;
	localparam logic [3:0] HAT_RIGHT = 4'd2;
	localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
	localparam logic [3:0] HAT_DOWN = 4'd4;
	localparam logic [3:0] HAT_DOWN_LEFT = 4'd5;
	localparam logic [3:0] HAT_LEFT = 4'd6;
	localparam logic [3:0] HAT_UP_LEFT = 4'd7;
	localparam logic [3:0] HAT_CENTER = 4'd8;

	localparam logic [6:0] KEY_TABLE [NUM_KEYS] = '{
		7'h00, 7'h01, 7'h26, 7'h28, 7'h25, 7'h7E, 7'h7D, 7'h24, 7'h35, 7'h31
	};

	typedef struct packed {
		logic kind;
		logic [NUM_KEYS-1:0] mask;
		logic [NUM_KEYS-1:0] levels;
		logic changed;
		logic [6:0] buttons;
		logic [3:0] hat;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
	} job_t;

	typedef struct packed {
		logic kind;
		logic [6:0] key_code;
		logic pressed;
		logic [6:0] pad_buttons;
		logic [3:0] hat;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic changed;
		logic last;
	} out_item_t;

endpackage
`default_nettype wire

// ----- src/gpkev_if.sv -----
// Valid/ready channel interfaces for input reports and result items.
`default_nettype none
interface gpkev_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [6:0] report_length;
	logic [7:0] report_type;
	logic [7:0] dpad_byte;
	logic [7:0] face_byte;
	logic [7:0] left_trigger;
	logic [7:0] right_trigger;
	logic signed [15:0] left_x;
	logic signed [15:0] left_y;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;

	modport source (output valid, opcode, report_length, report_type, dpad_byte, face_byte,
		left_trigger, right_trigger, left_x, left_y, right_x, right_y, input ready);
	modport sink (input valid, opcode, report_length, report_type, dpad_byte, face_byte,
		left_trigger, right_trigger, left_x, left_y, right_x, right_y, output ready);
endinterface

interface gpkev_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic [6:0] key_code;
	logic pressed;
	logic [6:0] pad_buttons;
	logic [3:0] hat;
	logic signed [15:0] out_left_x;
	logic signed [15:0] out_left_y;
	logic signed [15:0] out_right_x;
	logic signed [15:0] out_right_y;
	logic changed;
	logic last;

	modport source (output valid, kind, key_code, pressed, pad_buttons, hat, out_left_x,
		out_left_y, out_right_x, out_right_y, changed, last, input ready);
	modport sink (input valid, kind, key_code, pressed, pad_buttons, hat, out_left_x,
		out_left_y, out_right_x, out_right_y, changed, last, output ready);
endinterface
`default_nettype wire

// ----- src/gpkev_front.sv -----
// Front end: configuration registers, report decode, change detection and job creation.
`default_nettype none
module gpkev_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_idx,
	input wire logic [15:0] cfg_wdata,
	gpkev_in_if.sink in_ch,
	input wire logic q_full,
	output logic q_push,
	output gpkev_pkg::job_t q_job
);
	import gpkev_pkg::*;

	logic output_mode_q;
	logic [15:0] tilt_threshold_q;
	logic [7:0] trigger_delta_q;
	logic [15:0] axis_delta_q;
	logic [NUM_KEYS-1:0] held_keys_q;
	logic [7:0] last_trig_q [2];
	logic signed [15:0] last_axis_q [4];

	logic accept;
	logic keep;
	logic analog;
	logic chg;
	logic up, down, left, right;
	logic [NUM_KEYS-1:0] lv;
	logic [3:0] hat;
	logic [7:0] trg [2];
	logic signed [15:0] axs [4];

	function automatic logic [8:0] abs_diff8(logic [7:0] a, logic [7:0] b);
		logic [8:0] d;
		d = {1'b0, a} - {1'b0, b};
		return d[8] ? 9'(-d) : d;
	endfunction

	function automatic logic [16:0] abs_diff16(logic [15:0] a, logic [15:0] b);
		logic [16:0] d;
		d = {a[15], a} - {b[15], b};
		return d[16] ? 17'(-d) : d;
	endfunction

	assign in_ch.ready = !q_full;
	assign accept = in_ch.valid && !q_full;
	assign keep = (in_ch.opcode == OPC_REPORT) && (in_ch.report_type == 8'd0)
		&& (in_ch.report_length >= 7'(MIN_REPORT_LEN));

	assign trg[0] = in_ch.left_trigger;
	assign trg[1] = in_ch.right_trigger;
	assign axs[0] = in_ch.left_x;
	assign axs[1] = in_ch.left_y;
	assign axs[2] = in_ch.right_x;
	assign axs[3] = in_ch.right_y;

	assign up = in_ch.dpad_byte[0];
	assign down = in_ch.dpad_byte[1];
	assign left = in_ch.dpad_byte[2];
	assign right = in_ch.dpad_byte[3];

	always_comb begin
		lv[0] = in_ch.face_byte[4];
		lv[1] = in_ch.face_byte[5];
		lv[2] = in_ch.face_byte[7];
		lv[3] = in_ch.face_byte[6];
		lv[4] = in_ch.face_byte[0];
		lv[5] = up;
		lv[6] = down;
		lv[7] = in_ch.dpad_byte[4];
		lv[8] = in_ch.dpad_byte[5];
		lv[9] = in_ch.right_y > $signed(tilt_threshold_q);
	end

	always_comb begin
		analog = 1'b0;
		for (int i = 0; i < 2; i++) begin
			if (abs_diff8(trg[i], last_trig_q[i]) > {1'b0, trigger_delta_q}) begin
				analog = 1'b1;
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (abs_diff16(axs[i], last_axis_q[i]) > {1'b0, axis_delta_q}) begin
				analog = 1'b1;
			end
		end
	end

	assign chg = analog || (lv != held_keys_q);

	always_comb begin
		if (up && left) begin
			hat = HAT_UP_LEFT;
		end else if (up && right) begin
			hat = HAT_UP_RIGHT;
		end else if (down && left) begin
			hat = HAT_DOWN_LEFT;
		end else if (down && right) begin
			hat = HAT_DOWN_RIGHT;
		end else if (up) begin
			hat = HAT_UP;
		end else if (right) begin
			hat = HAT_RIGHT;
		end else if (down) begin
			hat = HAT_DOWN;
		end else if (left) begin
			hat = HAT_LEFT;
		end else begin
			hat = HAT_CENTER;
		end
	end

	always_comb begin
		q_job = '0;
		q_push = 1'b0;
		if (in_ch.opcode == OPC_RELEASE_ALL) begin
			q_job.kind = KIND_KEY;
			q_job.mask = held_keys_q;
			q_push = accept && (held_keys_q != '0);
		end else if (output_mode_q) begin
			q_job.kind = KIND_PAD;
			q_job.changed = chg;
			q_job.buttons = {lv[8:7], lv[4:0]};
			q_job.hat = hat;
			q_job.left_x = in_ch.left_x;
			q_job.left_y = in_ch.left_y;
			q_job.right_x = in_ch.right_x;
			q_job.right_y = in_ch.right_y;
			q_push = accept && keep;
		end else begin
			q_job.kind = KIND_KEY;
			q_job.mask = lv ^ held_keys_q;
			q_job.levels = lv;
			q_job.changed = chg;
			q_push = accept && keep && (lv != held_keys_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_mode_q <= 1'b0;
			tilt_threshold_q <= TILT_THRESHOLD_RESET;
			trigger_delta_q <= TRIGGER_DELTA_RESET;
			axis_delta_q <= AXIS_DELTA_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_OUTPUT_MODE: output_mode_q <= cfg_wdata[0];
				CFG_TILT_THRESHOLD: tilt_threshold_q <= cfg_wdata;
				CFG_TRIGGER_DELTA: trigger_delta_q <= cfg_wdata[7:0];
				CFG_AXIS_DELTA: axis_delta_q <= cfg_wdata;
				default: output_mode_q <= output_mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_keys_q <= '0;
			last_trig_q[0] <= '0;
			last_trig_q[1] <= '0;
			for (int i = 0; i < 4; i++) begin
				last_axis_q[i] <= '0;
			end
		end else if (accept) begin
			if (in_ch.opcode == OPC_RELEASE_ALL) begin
				held_keys_q <= '0;
			end else if (keep) begin
				if (!output_mode_q) begin
					held_keys_q <= lv;
				end
				if (chg) begin
					last_trig_q[0] <= trg[0];
					last_trig_q[1] <= trg[1];
					for (int i = 0; i < 4; i++) begin
						last_axis_q[i] <= axs[i];
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/gpkev_queue.sv -----
// Short job queue between the decode front end and the event back end.
`default_nettype none
module gpkev_queue #(
	parameter int DEPTH = gpkev_pkg::QUEUE_DEPTH_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire gpkev_pkg::job_t push_job,
	output logic full,
	input wire logic pop,
	output logic avail,
	output gpkev_pkg::job_t pop_job
);
	import gpkev_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign avail = (count_q != '0);
	assign pop_job = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && avail;

	function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/gpkev_back.sv -----
// Back end: serializes queued jobs into key events or gamepad reports.
`default_nettype none
module gpkev_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_avail,
	input wire gpkev_pkg::job_t q_job,
	output logic q_pop,
	gpkev_out_if.source out_ch
);
	import gpkev_pkg::*;

	job_t job_q;
	logic [NUM_KEYS-1:0] rem_q;
	logic busy_q;
	out_item_t out_q;
	logic out_valid_q;

	logic out_free;
	logic fire;
	logic done;
	logic [NUM_KEYS-1:0] low;
	logic [NUM_KEYS-1:0] rem_next;
	out_item_t item;

	assign low = rem_q & (~rem_q + 1'b1);
	assign rem_next = rem_q & ~low;
	assign out_free = !out_valid_q || out_ch.ready;
	assign fire = busy_q && out_free;
	assign done = fire && item.last;
	assign q_pop = q_avail && (!busy_q || done);

	always_comb begin
		item = '0;
		item.kind = job_q.kind;
		item.changed = job_q.changed;
		if (job_q.kind == KIND_PAD) begin
			item.pad_buttons = job_q.buttons;
			item.hat = job_q.hat;
			item.left_x = job_q.left_x;
			item.left_y = job_q.left_y;
			item.right_x = job_q.right_x;
			item.right_y = job_q.right_y;
			item.last = 1'b1;
		end else begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (low[i]) begin
					item.key_code = KEY_TABLE[i];
					item.pressed = job_q.levels[i];
				end
			end
			item.last = (rem_next == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			rem_q <= q_job.mask;
		end else if (fire) begin
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= item;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = out_q.kind;
	assign out_ch.key_code = out_q.key_code;
	assign out_ch.pressed = out_q.pressed;
	assign out_ch.pad_buttons = out_q.pad_buttons;
	assign out_ch.hat = out_q.hat;
	assign out_ch.out_left_x = out_q.left_x;
	assign out_ch.out_left_y = out_q.left_y;
	assign out_ch.out_right_x = out_q.right_x;
	assign out_ch.out_right_y = out_q.right_y;
	assign out_ch.changed = out_q.changed;
	assign out_ch.last = out_q.last;
endmodule
`default_nettype wire

// ----- src/gamepad_report_to_key_events.sv -----
// Top level of the gamepad report decoder with key-event and gamepad-report outputs.
// Usage:
// The in_ch channel takes one item per handshake: an input report or a release-all
// request. The out_ch channel delivers the result items; the final one of an input
// carries last. Configuration is written through cfg_we, cfg_idx and cfg_wdata while
// the block is idle; a write takes effect at the next clock edge.
// An input item is decoded and its state updated in the cycle it is accepted; its
// first result passes the queue, the job register and the output register before it
// appears on out_ch. A gamepad report is a single item, a key-event burst is one item
// per cycle while out_ch is ready, up to ten. The event serializer sets the rate: one
// result per cycle while out_ch is ready, and a one-result item can follow every cycle.
// The queue holds QUEUE_DEPTH decoded items; in_ch.ready drops while it is full.
// When the receiver stalls, the output register holds its item, the serializer
// waits and the queue fills before the input side stalls.
// Reset clears the held keys, the stored analog values, the queue and the output
// valid flag, and loads the configuration registers with their defaults.
`default_nettype none
module gamepad_report_to_key_events #(
	parameter int QUEUE_DEPTH = gpkev_pkg::QUEUE_DEPTH_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_idx,
	input wire logic [15:0] cfg_wdata,
	gpkev_in_if.sink in_ch,
	gpkev_out_if.source out_ch
);
	import gpkev_pkg::*;

	job_t push_job;
	job_t pop_job;
	logic push;
	logic full;
	logic pop;
	logic avail;

	gpkev_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.q_full(full),
		.q_push(push),
		.q_job(push_job)
	);

	gpkev_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(full),
		.pop(pop),
		.avail(avail),
		.pop_job(pop_job)
	);

	gpkev_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_avail(avail),
		.q_job(pop_job),
		.q_pop(pop),
		.out_ch(out_ch)
	);
endmodule
`default_nettype wire

// ----- src/gpkev_checker.sv -----
// Port-level assertion checker for the gamepad decoder and its bind statement.
`default_nettype none
`include "gamepad_report_to_key_events_assert.svh"
module gpkev_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_kind,
	input wire logic [6:0] out_key_code,
	input wire logic out_pressed,
	input wire logic [6:0] out_pad_buttons,
	input wire logic [3:0] out_hat,
	input wire logic [15:0] out_lx,
	input wire logic [15:0] out_ly,
	input wire logic [15:0] out_rx,
	input wire logic [15:0] out_ry,
	input wire logic out_changed,
	input wire logic out_last
);
	logic [85:0] payload;
	logic key_fields_clear;
	logic pad_fields_clear;

	assign payload = {out_kind, out_key_code, out_pressed, out_pad_buttons, out_hat,
		out_lx, out_ly, out_rx, out_ry, out_changed, out_last};
	assign key_fields_clear = (out_key_code == 7'd0) && !out_pressed;
	assign pad_fields_clear = (out_hat == 4'd0) && (out_pad_buttons == 7'd0)
		&& (out_lx == 16'd0) && (out_ry == 16'd0);

	`GPKEV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`GPKEV_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(payload))
	`GPKEV_ASSERT_SAME(a_pad_is_last, clk, arst_n, out_valid && out_kind, out_last && key_fields_clear)
	`GPKEV_ASSERT_SAME(a_key_no_pad, clk, arst_n, out_valid && !out_kind, pad_fields_clear)
endmodule

bind gamepad_report_to_key_events gpkev_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_kind(out_ch.kind),
	.out_key_code(out_ch.key_code),
	.out_pressed(out_ch.pressed),
	.out_pad_buttons(out_ch.pad_buttons),
	.out_hat(out_ch.hat),
	.out_lx(out_ch.out_left_x),
	.out_ly(out_ch.out_left_y),
	.out_rx(out_ch.out_right_x),
	.out_ry(out_ch.out_right_y),
	.out_changed(out_ch.changed),
	.out_last(out_ch.last)
);
`default_nettype wire

// ----- tb/tb_gamepad_report_to_key_events.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the gamepad report decoder with a predicting scoreboard.
module tb_gamepad_report_to_key_events;
	import gpkev_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 42;
	localparam logic [6:0] CONTROL_KEY [NUM_KEYS] = '{
		7'h00, 7'h01, 7'h26, 7'h28, 7'h25, 7'h7E, 7'h7D, 7'h24, 7'h35, 7'h31
	};

	typedef struct packed {
		logic opcode;
		logic [6:0] len;
		logic [7:0] rtype;
		logic [7:0] dpad;
		logic [7:0] face;
		logic [7:0] ltrig;
		logic [7:0] rtrig;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;

	gpkev_in_if report_ch ();
	gpkev_out_if event_ch ();

	gamepad_report_to_key_events dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_ch(report_ch),
		.out_ch(event_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state and its copy of the configuration.
	logic pad_mode;
	logic signed [15:0] tilt_level;
	logic [7:0] trigger_gate;
	logic [15:0] axis_gate;
	logic [NUM_KEYS-1:0] held_controls;
	logic [7:0] seen_triggers [2];
	logic signed [15:0] seen_axes [4];

	report_t outgoing [$];
	out_item_t expected_events [$];
	report_t on_wire;
	report_t last_report;
	int issued = 0;
	int accepted = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int calm_cycles = 0;
	int send_gap = 0;
	int hold_off = 0;

	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic decode_report(input report_t r);
		logic [NUM_KEYS-1:0] lv;
		logic [3:0] hat;
		logic moved;
		logic up, down, left, right;
		logic signed [15:0] axv [4];
		int trg [2];
		int d;
		out_item_t ev;
		out_item_t burst [$];
		if (r.opcode == OPC_RELEASE_ALL) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (held_controls[i]) begin
					ev = '0;
					ev.kind = KIND_KEY;
					ev.key_code = CONTROL_KEY[i];
					burst.push_back(ev);
				end
			end
			held_controls = '0;
		end else if (r.len >= MIN_REPORT_LEN && r.rtype == 8'd0) begin
			up = r.dpad[0];
			down = r.dpad[1];
			left = r.dpad[2];
			right = r.dpad[3];
			axv = '{r.lx, r.ly, r.rx, r.ry};
			trg[0] = int'(r.ltrig);
			trg[1] = int'(r.rtrig);
			lv = {int'(r.ry) > int'(tilt_level), r.dpad[5], r.dpad[4], down, up,
				r.face[0], r.face[6], r.face[7], r.face[5], r.face[4]};
			moved = 1'b0;
			for (int i = 0; i < 2; i++) begin
				d = trg[i] - int'(seen_triggers[i]);
				if ((d < 0 ? -d : d) > int'(trigger_gate)) moved = 1'b1;
			end
			for (int i = 0; i < 4; i++) begin
				d = int'(axv[i]) - int'(seen_axes[i]);
				if ((d < 0 ? -d : d) > int'(axis_gate)) moved = 1'b1;
			end
			moved = moved || (lv != held_controls);
			if (moved) begin
				seen_triggers[0] = r.ltrig;
				seen_triggers[1] = r.rtrig;
				seen_axes = axv;
			end
			if (pad_mode) begin
				if (up && left) hat = HAT_UP_LEFT;
				else if (up && right) hat = HAT_UP_RIGHT;
				else if (down && left) hat = HAT_DOWN_LEFT;
				else if (down && right) hat = HAT_DOWN_RIGHT;
				else if (up) hat = HAT_UP;
				else if (right) hat = HAT_RIGHT;
				else if (down) hat = HAT_DOWN;
				else if (left) hat = HAT_LEFT;
				else hat = HAT_CENTER;
				ev = '0;
				ev.kind = KIND_PAD;
				ev.pad_buttons = {lv[8:7], lv[4:0]};
				ev.hat = hat;
				ev.left_x = r.lx;
				ev.left_y = r.ly;
				ev.right_x = r.rx;
				ev.right_y = r.ry;
				ev.changed = moved;
				burst.push_back(ev);
			end else begin
				for (int i = 0; i < NUM_KEYS; i++) begin
					if (lv[i] != held_controls[i]) begin
						ev = '0;
						ev.kind = KIND_KEY;
						ev.key_code = CONTROL_KEY[i];
						ev.pressed = lv[i];
						ev.changed = moved;
						burst.push_back(ev);
					end
				end
				held_controls = lv;
			end
		end
		if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i]) expected_events.push_back(burst[i]);
	endtask

	task automatic compare_field(input string label, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (report_ch.valid && report_ch.ready) begin
				decode_report(on_wire);
				accepted++;
			end
			if (!report_ch.valid || report_ch.ready) begin
				if (send_gap > 0 || outgoing.size() == 0) begin
					if (send_gap > 0) send_gap--;
					report_ch.valid <= 1'b0;
				end else begin
					on_wire = outgoing.pop_front();
					report_ch.valid <= 1'b1;
					report_ch.opcode <= on_wire.opcode;
					report_ch.report_length <= on_wire.len;
					report_ch.report_type <= on_wire.rtype;
					report_ch.dpad_byte <= on_wire.dpad;
					report_ch.face_byte <= on_wire.face;
					report_ch.left_trigger <= on_wire.ltrig;
					report_ch.right_trigger <= on_wire.rtrig;
					report_ch.left_x <= on_wire.lx;
					report_ch.left_y <= on_wire.ly;
					report_ch.right_x <= on_wire.rx;
					report_ch.right_y <= on_wire.ry;
					send_gap = calm_cycles > 0 ? 0 : draw_gap();
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			event_ch.ready <= 1'b0;
			hold_off = 0;
		end else begin
			if (event_ch.valid && event_ch.ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h %h %h",
						$time, event_ch.kind, event_ch.key_code, event_ch.pressed);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					compare_field("kind", want.kind, event_ch.kind);
					compare_field("key_code", want.key_code, event_ch.key_code);
					compare_field("pressed", want.pressed, event_ch.pressed);
					compare_field("pad_buttons", want.pad_buttons, event_ch.pad_buttons);
					compare_field("hat", want.hat, event_ch.hat);
					compare_field("out_left_x", want.left_x, event_ch.out_left_x);
					compare_field("out_left_y", want.left_y, event_ch.out_left_y);
					compare_field("out_right_x", want.right_x, event_ch.out_right_x);
					compare_field("out_right_y", want.right_y, event_ch.out_right_y);
					compare_field("changed", want.changed, event_ch.changed);
					compare_field("last", want.last, event_ch.last);
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				event_ch.ready <= 1'b0;
			end else begin
				event_ch.ready <= 1'b1;
				if (calm_cycles == 0 && $urandom_range(0, 3) == 0) hold_off = draw_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (calm_cycles > 0) calm_cycles--;
		else if ($urandom_range(0, 499) == 0) calm_cycles = $urandom_range(50, 200);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_gamepad_report_to_key_events: done, errors");
			$finish;
		end
	end

	function automatic report_t pad_report(input logic [6:0] len, input logic [7:0] rtype,
		input logic [7:0] dpad, input logic [7:0] face, input logic [7:0] ltrig,
		input logic [7:0] rtrig, input logic [15:0] lx, input logic [15:0] ly,
		input logic [15:0] rx, input logic [15:0] ry);
		report_t r;
		r.opcode = OPC_REPORT;
		r.len = len;
		r.rtype = rtype;
		r.dpad = dpad;
		r.face = face;
		r.ltrig = ltrig;
		r.rtrig = rtrig;
		r.lx = lx;
		r.ly = ly;
		r.rx = rx;
		r.ry = ry;
		return r;
	endfunction

	task automatic send(input report_t r);
		outgoing.push_back(r);
		issued++;
	endtask

	task automatic settle();
		while (accepted != issued || expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_OUTPUT_MODE: pad_mode = value[0];
			CFG_TILT_THRESHOLD: tilt_level = value;
			CFG_TRIGGER_DELTA: trigger_gate = value[7:0];
			CFG_AXIS_DELTA: axis_gate = value;
			default: pad_mode = pad_mode;
		endcase
	endtask

	task automatic program_block(input logic mode, input logic [15:0] tilt,
		input logic [7:0] tdelta, input logic [15:0] adelta);
		write_reg(CFG_OUTPUT_MODE, {15'd0, mode});
		write_reg(CFG_TILT_THRESHOLD, tilt);
		write_reg(CFG_TRIGGER_DELTA, {8'd0, tdelta});
		write_reg(CFG_AXIS_DELTA, adelta);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		int kept;
		int roll;
		int nudge;
		report_t r;
		kept = 0;
		while (kept < count) begin
			roll = $urandom_range(0, 99);
			r.opcode = OPC_REPORT;
			r.len = 7'($urandom);
			r.rtype = 8'($urandom);
			r.dpad = 8'($urandom);
			r.face = 8'($urandom);
			r.ltrig = 8'($urandom);
			r.rtrig = 8'($urandom);
			r.lx = 16'($urandom);
			r.ly = 16'($urandom);
			r.rx = 16'($urandom);
			r.ry = 16'($urandom);
			if (roll < 8) begin
				r.opcode = OPC_RELEASE_ALL;
				kept++;
			end else if (roll < 16) begin
				if ($urandom_range(0, 1) == 1)
					r.len = 7'($urandom_range(0, MIN_REPORT_LEN - 1));
				else
					r.rtype = 8'($urandom_range(1, 255));
			end else begin
				if (roll < 70) begin
					// Mostly small moves from the previous report, straddling the thresholds.
					r = last_report;
					if (roll >= 30) begin
						r.dpad[$urandom_range(0, 7)] ^= 1'b1;
						r.face[$urandom_range(0, 7)] ^= 1'b1;
						nudge = int'(trigger_gate) + int'($urandom_range(0, 1));
						if ($urandom_range(0, 1) == 1) r.ltrig += 8'(nudge);
						else r.rtrig -= 8'(nudge);
						nudge = int'(axis_gate) + int'($urandom_range(0, 1));
						if ($urandom_range(0, 1) == 1) nudge = -nudge;
						case ($urandom_range(0, 3))
							0: r.lx += 16'(nudge);
							1: r.ly += 16'(nudge);
							2: r.rx += 16'(nudge);
							default: r.ry += 16'(nudge);
						endcase
					end
				end
				r.rtype = 8'd0;
				case ($urandom_range(0, 3))
					0: r.len = 7'(MIN_REPORT_LEN);
					1: r.len = 7'd64;
					2: r.len = 7'd127;
					default: r.len = 7'($urandom_range(MIN_REPORT_LEN, 127));
				endcase
				if ($urandom_range(0, 3) == 0)
					r.ry = 16'(int'(tilt_level) + int'($urandom_range(0, 4)) - 2);
				last_report = r;
				kept++;
			end
			send(r);
		end
	endtask

	task automatic run_phase(input logic mode, input logic [15:0] tilt,
		input logic [7:0] tdelta, input logic [15:0] adelta);
		program_block(mode, tilt, tdelta, adelta);
		random_phase(PHASE_ITEMS);
		settle();
	endtask

	initial begin
		report_t rel;
		report_ch.valid = 1'b0;
		report_ch.opcode = 1'b0;
		report_ch.report_length = '0;
		report_ch.report_type = '0;
		report_ch.dpad_byte = '0;
		report_ch.face_byte = '0;
		report_ch.left_trigger = '0;
		report_ch.right_trigger = '0;
		report_ch.left_x = '0;
		report_ch.left_y = '0;
		report_ch.right_x = '0;
		report_ch.right_y = '0;
		event_ch.ready = 1'b0;
		pad_mode = 1'b0;
		tilt_level = TILT_THRESHOLD_RESET;
		trigger_gate = TRIGGER_DELTA_RESET;
		axis_gate = AXIS_DELTA_RESET;
		held_controls = '0;
		seen_triggers = '{default: '0};
		seen_axes = '{default: '0};
		last_report = pad_report(7'(MIN_REPORT_LEN), 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
			16'd0, 16'd0, 16'd0, 16'd0);
		rel = last_report;
		rel.opcode = OPC_RELEASE_ALL;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Key events under the reset configuration.
		send(pad_report(7'd14, 8'd0, 8'hFF, 8'hFF, 8'd255, 8'd255,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF));
		send(pad_report(7'd14, 8'd0, 8'hFF, 8'hFF, 8'd255, 8'd255,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF));
		send(rel);
		send(rel);
		send(pad_report(7'd13, 8'd0, 8'hFF, 8'hFF, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		send(pad_report(7'd127, 8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0,
			16'd0, 16'd0, 16'd0, 16'd0));
		send(pad_report(7'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		send(pad_report(7'd127, 8'd0, 8'h00, 8'h10, 8'd0, 8'd0,
			16'd0, 16'd0, 16'd0, 16'd22000));
		send(pad_report(7'd64, 8'd0, 8'h00, 8'h10, 8'd0, 8'd0,
			16'd0, 16'd0, 16'd0, 16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h00, 8'h10, 8'd21, 8'd0,
			16'd0, 16'd0, 16'd0, 16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h22, 8'h21, 8'd21, 8'd20,
			16'd2001, 16'd0, 16'd0, 16'd22001));
		send(pad_report(7'd14, 8'd0, 8'hC0, 8'h4E, 8'd21, 8'd20,
			16'd2001, 16'd0, 16'd0, 16'd22001));
		settle();

		// Gamepad reports: every hat direction, a report equal to the held levels,
		// and a release of the keys left held by the key-event part.
		program_block(1'b1, TILT_THRESHOLD_RESET, TRIGGER_DELTA_RESET, AXIS_DELTA_RESET);
		send(pad_report(7'd14, 8'd0, 8'h05, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h09, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h06, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h0A, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h01, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h08, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h02, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h04, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h00, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h3F, 8'hF1, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(pad_report(7'd14, 8'd0, 8'h00, 8'h40, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		send(rel);
		send(pad_report(7'd14, 8'd0, 8'h00, 8'h40, 8'd21, 8'd20, 16'd2001, 16'd0, 16'd0,
			16'd22001));
		settle();

		run_phase(1'b1, 16'h8000, 8'd0, 16'd0);
		run_phase(1'b0, 16'h7FFF, 8'd255, 16'hFFFF);
		run_phase(1'b0, TILT_THRESHOLD_RESET, TRIGGER_DELTA_RESET, AXIS_DELTA_RESET);
		run_phase(1'b1, 16'($urandom), 8'($urandom), 16'($urandom));
		run_phase(1'b0, 16'($urandom), 8'($urandom_range(0, 40)),
			16'($urandom_range(0, 4000)));

		if (mismatches == 0) begin
			$display("tb_gamepad_report_to_key_events: done, clean");
		end else begin
			$display("tb_gamepad_report_to_key_events: done, errors");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+src
src/gpkev_pkg.sv
src/gpkev_if.sv
src/gpkev_front.sv
src/gpkev_queue.sv
src/gpkev_back.sv
src/gamepad_report_to_key_events.sv
src/gpkev_checker.sv
tb/tb_gamepad_report_to_key_events.sv
